>>> rtl/core/rnr_pkg.sv
// Shared width constant and sequencer state type for the rational reduction core.
package rnr_pkg;

  localparam int DEF_WIDTH = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } rnr_state_t;

endpackage

>>> rtl/core/rnr_cmpsub.sv
// Shared compare and absolute-difference unit used by the GCD and divide steps.
module rnr_cmpsub
  import rnr_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  output logic             ge,
  output logic [WIDTH-1:0] diff
);

  logic [WIDTH:0] d;

  assign d    = {1'b0, x} - {1'b0, y};
  assign ge   = ~d[WIDTH];
  assign diff = ge ? d[WIDTH-1:0] : (WIDTH'(0) - d[WIDTH-1:0]);

endmodule

>>> rtl/core/rational_normalize_reduce_core.sv
// Top level of the rational reduction core: sequencer, datapath and output register.
//
// Usage: one fraction enters on the input channel (numerator_in, denominator_in,
// in_valid / in_stall) and one reduced fraction leaves on the output channel
// (numerator_out, denominator_out, out_valid / out_stall). A transfer happens on a
// rising edge with valid high and stall low.
// A zero denominator counts as one, the denominator's sign moves to the numerator,
// a zero numerator gives 0 / 1, and otherwise both parts are divided by their GCD.
// After an input transfer the core runs the binary GCD steps (none for a zero
// numerator), then two restoring divisions of WIDTH steps each, all on the one
// shared compare/subtract unit. The next input transfer can follow in the cycle
// after the result is loaded. in_stall stays high from a transfer until the
// result is handed to the output register.
// The output register holds the result while out_stall is high; a new item may
// enter meanwhile, and its finished result waits until the register is free.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module rational_normalize_reduce_core
  import rnr_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [WIDTH-1:0] numerator_in,
  input  logic signed [WIDTH-1:0] denominator_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WIDTH-1:0] numerator_out,
  output logic        [WIDTH-2:0] denominator_out
);

  localparam int KW = $clog2(WIDTH);
  localparam logic [KW-1:0] LAST = KW'(WIDTH - 1);
  localparam logic [WIDTH-2:0] MAX_MAG = '1;

  rnr_state_t state, state_next;

  logic [WIDTH-1:0] ga, gb, dv, dq, rem, qn, dmag;
  logic [KW-1:0]    k, cnt;
  logic             neg;
  logic             out_load;

  logic [WIDTH-1:0] den_fix, nmag_in, dmag_in, sh, ux, uy, udiff;
  logic             uge, gcd_done, cnt_last;
  logic [WIDTH-2:0] sat_n, sat_d;

  assign den_fix  = (denominator_in == '0) ? WIDTH'(1) : denominator_in;
  assign nmag_in  = numerator_in[WIDTH-1] ? (WIDTH'(0) - numerator_in) : numerator_in;
  assign dmag_in  = den_fix[WIDTH-1] ? (WIDTH'(0) - den_fix) : den_fix;
  assign gcd_done = (ga == '0) || (gb == '0);
  assign cnt_last = (cnt == LAST);
  assign sh       = {rem[WIDTH-2:0], dq[WIDTH-1]};

  always_comb begin
    ux = (state == S_GCD) ? ga : sh;
    uy = (state == S_GCD) ? gb : dv;
  end

  rnr_cmpsub #(.WIDTH(WIDTH)) u_cmpsub (
    .x    (ux),
    .y    (uy),
    .ge   (uge),
    .diff (udiff)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_GCD;
      S_GCD:  if (gcd_done) state_next = S_DIVN;
      S_DIVN: if (cnt_last) state_next = S_DIVD;
      S_DIVD: if (cnt_last) state_next = S_FIN;
      S_FIN:  if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    out_load = (state == S_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ga   <= nmag_in;
        gb   <= dmag_in;
        dq   <= nmag_in;
        dmag <= dmag_in;
        k    <= '0;
        neg  <= numerator_in[WIDTH-1] ^ den_fix[WIDTH-1];
      end
      S_GCD: begin
        priority if (gcd_done) begin
          dv  <= (ga | gb) << k;
          rem <= '0;
          cnt <= '0;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + KW'(1);
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (uge) begin
          ga <= udiff;
        end else begin
          gb <= udiff;
        end
      end
      S_DIVN, S_DIVD: begin
        if (cnt_last && state == S_DIVN) begin
          qn  <= {dq[WIDTH-2:0], uge};
          dq  <= dmag;
          rem <= '0;
          cnt <= '0;
        end else begin
          dq  <= {dq[WIDTH-2:0], uge};
          rem <= uge ? udiff : sh;
          cnt <= cnt + KW'(1);
        end
      end
      S_FIN: begin
        if (out_load) begin
          numerator_out   <= neg ? (WIDTH'(0) - {1'b0, sat_n}) : {1'b0, sat_n};
          denominator_out <= sat_d;
        end
      end
      default: begin
      end
    endcase
  end

  assign sat_n = qn[WIDTH-1] ? MAX_MAG : qn[WIDTH-2:0];
  assign sat_d = dq[WIDTH-1] ? MAX_MAG : dq[WIDTH-2:0];

  a_accept_starts_gcd: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_GCD))
    else $error("accepted transfer did not start the GCD loop");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN || state == S_DIVD) |-> (dv != '0))
    else $error("division started with a zero divisor");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("finished result not presented");

  a_den_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (denominator_out != '0))
    else $error("zero denominator on output");

endmodule

>>> tb/rational_normalize_reduce_core_tb.sv
// Self-checking testbench for the rational reduction core with random idling on both channels.
`timescale 1ns / 1ps

module rational_normalize_reduce_core_tb;
  import rnr_pkg::*;

  localparam int W = DEF_WIDTH;
  localparam longint MAX_MAG = (longint'(1) << (W - 1)) - 1;
  localparam int RANDOM_FRACTIONS = 1900;
  localparam int SETTLE_CYCLES = 8 * W;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [W-1:0] num;
    logic signed [W-1:0] den;
  } fraction_t;

  typedef struct {
    logic signed [W-1:0] num;
    logic [W-2:0] den;
  } reduced_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] numerator_in = '0;
  logic signed [W-1:0] denominator_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] numerator_out;
  logic [W-2:0] denominator_out;

  fraction_t pending_q[$];
  reduced_t reduced_q[$];
  int total_fractions = 0;
  int fractions_in = 0;
  int fractions_out = 0;
  int zero_num_seen = 0;
  int zero_den_seen = 0;
  int most_negative_seen = 0;
  int errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  longint cycle_count = 0;

  rational_normalize_reduce_core #(.WIDTH(W)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .numerator_in(numerator_in),
    .denominator_in(denominator_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .numerator_out(numerator_out),
    .denominator_out(denominator_out)
  );

  always #4 clk = ~clk;

  function automatic reduced_t reduce_fraction(input logic signed [W-1:0] n_in,
                                               input logic signed [W-1:0] d_in);
    reduced_t res;
    longint n, d, nm, dm, a, b, r;
    bit neg;
    n = n_in;
    d = d_in;
    if (d == 0) d = 1;
    if (n == 0) begin
      res.num = '0;
      res.den = (W-1)'(1);
      return res;
    end
    neg = (n < 0) != (d < 0);
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    a = nm;
    b = dm;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    if (a == 0) a = 1;
    nm = nm / a;
    dm = dm / a;
    if (nm > MAX_MAG) nm = MAX_MAG;
    if (dm > MAX_MAG) dm = MAX_MAG;
    res.num = W'(neg ? -nm : nm);
    res.den = (W-1)'(dm);
    return res;
  endfunction

  function automatic bit calm_phase();
    return (cycle_count % 3000) < 600;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase() || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [W-1:0] random_signed(input int lo, input int hi);
    int v;
    v = lo + int'($urandom_range(0, hi - lo));
    return W'(v);
  endfunction

  task automatic add_fraction(input int n, input int d);
    fraction_t f;
    f.num = W'(n);
    f.den = W'(d);
    pending_q.push_back(f);
    total_fractions++;
  endtask

  task automatic add_random_fraction();
    int kind, g, a, b;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      add_fraction($urandom & 16'hffff, $urandom & 16'hffff);
    end else if (kind < 80) begin
      g = $urandom_range(2, 181);
      a = $urandom_range(0, 32767 / g) * g;
      b = $urandom_range(0, 32767 / g) * g;
      add_fraction($urandom_range(0, 1) ? -a : a, $urandom_range(0, 1) ? -b : b);
    end else if (kind < 92) begin
      add_fraction(random_signed(-20, 20), random_signed(-20, 20));
    end else begin
      case ($urandom_range(0, 3))
        0: add_fraction(0, $urandom & 16'hffff);
        1: add_fraction($urandom & 16'hffff, 0);
        2: add_fraction(-32768, $urandom & 16'hffff);
        default: add_fraction($urandom & 16'hffff, -32768);
      endcase
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d fractions in, %0d results waiting",
               cycle_count, fractions_in, total_fractions, reduced_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    fraction_t f;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        reduced_q.push_back(reduce_fraction(numerator_in, denominator_in));
        fractions_in++;
        if (numerator_in == 0) zero_num_seen++;
        if (denominator_in == 0) zero_den_seen++;
        if (numerator_in == -32768 || denominator_in == -32768) most_negative_seen++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_q.size() > 0) begin
          f = pending_q.pop_front();
          in_valid <= 1'b1;
          numerator_in <= f.num;
          denominator_in <= f.den;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    reduced_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        fractions_out++;
        if (reduced_q.size() == 0) begin
          $error("unexpected result %0d / %0d", numerator_out, denominator_out);
          errors++;
        end else begin
          exp_r = reduced_q.pop_front();
          if (numerator_out !== exp_r.num) begin
            $error("numerator_out: expected %0d, got %0d", exp_r.num, numerator_out);
            errors++;
          end
          if (denominator_out !== exp_r.den) begin
            $error("denominator_out: expected %0d, got %0d", exp_r.den, denominator_out);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!calm_phase() && $urandom_range(0, 9) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    add_fraction(0, 0);
    add_fraction(0, -5);
    add_fraction(0, -32768);
    add_fraction(5, 0);
    add_fraction(-5, 0);
    add_fraction(32767, 32767);
    add_fraction(-32767, 32767);
    add_fraction(32767, -32767);
    add_fraction(-32767, -32767);
    add_fraction(32767, 1);
    add_fraction(1, 32767);
    add_fraction(32767, 32766);
    add_fraction(1, 1);
    add_fraction(-1, -1);
    add_fraction(6, -4);
    add_fraction(-12, 18);
    add_fraction(30030, 4620);
    add_fraction(24576, -8192);
    add_fraction(-32768, 1);
    add_fraction(1, -32768);
    add_fraction(-32768, -32768);
    add_fraction(-32768, 0);
    add_fraction(-32768, 16384);
    add_fraction(16384, -32768);
    add_fraction(-21845, -32767);
    repeat (RANDOM_FRACTIONS) add_random_fraction();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (fractions_in < total_fractions || reduced_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d fractions in, %0d reduced results out, %0d mismatches",
             fractions_in, fractions_out, errors);
    $display("%0d zero numerators, %0d zero denominators, %0d with the most negative value",
             zero_num_seen, zero_den_seen, most_negative_seen);
    if (errors == 0 && reduced_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
